// ===== rtl/mcodo_pkg.sv =====
// Shared types and constants for the modular combination odometer.
// Used by the core, the remainder unit and the port checker.
package mcodo_pkg;

    // operation codes
    localparam logic [2:0] OP_LOAD        = 3'd0;
    localparam logic [2:0] OP_CLEAR       = 3'd1;
    localparam logic [2:0] OP_SET         = 3'd2;
    localparam logic [2:0] OP_INC         = 3'd3;
    localparam logic [2:0] OP_READ_ELEM   = 3'd4;
    localparam logic [2:0] OP_READ_COORD  = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_MODULUS    = 2'd0;
    localparam logic [1:0] CFG_RANK       = 2'd1;
    localparam logic [1:0] CFG_LENGTH     = 2'd2;

    // remainder unit: one quotient bit per cycle over a 33-bit dividend
    localparam int unsigned DIV_BITS = 33;
    localparam logic [5:0]  DIV_STEPS = 6'd33;

    typedef struct packed {
        logic [2:0]         operation;
        logic [4:0]         matrix_index;
        logic [9:0]         element_index;
        logic signed [31:0] value;
    } cmd_t;

    typedef struct packed {
        logic [15:0] read_value;
        logic        advanced;
        logic        overflow;
    } res_t;

    typedef struct packed {
        logic                start;
        logic [DIV_BITS-1:0] dividend;
        logic [15:0]         divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [15:0] remainder;
    } div_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD_DIV,
        ST_SET_DIV,
        ST_CLEAR,
        ST_RD_ISSUE,
        ST_RD_WAIT,
        ST_INC_CHECK,
        ST_W_RSRC,
        ST_W_RACC,
        ST_W_CALC,
        ST_W_MUL,
        ST_W_DIV,
        ST_W_END,
        ST_RESP
    } state_t;

endpackage

// ===== rtl/modular_combination_odometer_core.sv =====
// Modular combination odometer: top level with sequencer, vector memory and coordinates.
// Depends on mcodo_pkg, mcodo_ram and mcodo_rem.
//
// Usage: a command word is taken when start is high and busy is low. Each command
// gives exactly one result word, shown on result for one cycle with done high;
// the receiver cannot stall it. busy stays high from acceptance through the done
// cycle. Configuration words (cfg_valid/cfg_ready, always ready) must be written only
// while the block is idle; the block itself does not enforce this.
// Command paths:
//   load element: signed reduction in the shared remainder unit
//   set coordinate: one remainder pass per element
//   increment: the vector walk reads the basis and accumulator elements through the
//   single memory read port.
// Reset clears the coordinates, the overflow flag and the registers
// (modulus 2, rank 1, length 1); vector memory is undefined until loaded.
module modular_combination_odometer_core #(
    parameter int MAX_RANK   = 16,
    parameter int MAX_LENGTH = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  mcodo_pkg::cmd_t   cmd,
    output logic              done,
    output mcodo_pkg::res_t   result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data
);

    localparam int RW    = $clog2(MAX_RANK + 1);
    localparam int KW    = $clog2(MAX_LENGTH + 1);
    localparam int CIW   = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
    localparam int DEPTH = (MAX_RANK + 1) * MAX_LENGTH;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] LEN_A = AW'(MAX_LENGTH);

    mcodo_pkg::state_t  state_reg, state_next;
    mcodo_pkg::cmd_t    item_reg, item_next;
    logic [15:0]        mod_reg, rank_dummy;
    logic [4:0]         rank_reg;
    logic [10:0]        len_reg;
    logic [KW-1:0]      k_reg, k_next;
    logic [RW-1:0]      slot_reg, slot_next;
    logic [RW-1:0]      pos_reg, pos_next;
    logic               times_reg, times_next;
    logic               wrap_reg, wrap_next;
    logic               neg_reg, neg_next;
    logic [15:0]        coef_reg, coef_next;
    logic [15:0]        src_reg, src_next;
    logic [15:0]        acc_reg, acc_next;
    logic [31:0]        prod_reg, prod_next;
    logic [15:0]        rd_reg, rd_next;
    logic               adv_reg, adv_next;
    logic               ovf_reg, ovf_next;
    logic [15:0]        coord_reg [MAX_RANK];
    logic               coord_we;
    logic [CIW-1:0]     coord_widx;
    logic [15:0]        coord_wdata;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr, mem_raddr;
    logic [15:0]        mem_wdata, mem_rdata;

    mcodo_pkg::div_req_t div_req;
    mcodo_pkg::div_rsp_t div_rsp;

    logic [15:0]        mod_eff, top;
    logic [RW-1:0]      rank_eff;
    logic [KW-1:0]      len_eff, k_inc;
    logic               accept, cmd_elem_ok, cmd_coord_ok, k_last;
    logic [6:0]         cmd_cidx, item_cidx, pos_cidx;
    logic [31:0]        mag;
    logic [15:0]        reduced, coord_at_pos, sum_fix;
    logic [16:0]        sum_once;
    logic [AW-1:0]      item_addr;
    mcodo_pkg::state_t  walk_first;

    assign rank_dummy = '0;

    // effective configuration
    assign mod_eff  = (mod_reg == 16'd0) ? 16'd1 : mod_reg;
    assign top      = mod_eff - 16'd1;
    assign rank_eff = (7'(rank_reg) > 7'(MAX_RANK)) ? RW'(MAX_RANK) : RW'(rank_reg);
    assign len_eff  = (17'(len_reg) > 17'(MAX_LENGTH)) ? KW'(MAX_LENGTH) : KW'(len_reg);

    // command checks
    assign accept       = start && (state_reg == mcodo_pkg::ST_IDLE);
    assign cmd_elem_ok  = (7'(cmd.matrix_index) <= 7'(rank_eff))
                          && (17'(cmd.element_index) < 17'(len_eff));
    assign cmd_coord_ok = (cmd.matrix_index != 5'd0) && (7'(cmd.matrix_index) <= 7'(rank_eff));
    assign cmd_cidx     = 7'(cmd.matrix_index) - 7'd1;
    assign item_cidx    = 7'(item_reg.matrix_index) - 7'd1;
    assign pos_cidx     = 7'(pos_reg) - 7'd1;
    assign mag          = cmd.value[31] ? (~cmd.value + 32'd1) : cmd.value;
    assign item_addr    = AW'(item_reg.matrix_index) * LEN_A + AW'(item_reg.element_index);
    assign coord_at_pos = coord_reg[pos_cidx[CIW-1:0]];

    // walk step helpers
    assign k_inc      = k_reg + KW'(1);
    assign k_last     = (k_inc == len_eff);
    assign walk_first = (len_eff == KW'(0)) ? mcodo_pkg::ST_W_END : mcodo_pkg::ST_W_RSRC;
    assign sum_once   = {1'b0, mem_rdata} + {1'b0, src_reg};
    assign sum_fix    = (sum_once >= {1'b0, mod_eff}) ? 16'(sum_once - {1'b0, mod_eff})
                                                      : sum_once[15:0];
    assign reduced    = (neg_reg && (div_rsp.remainder != 16'd0))
                        ? (mod_eff - div_rsp.remainder) : div_rsp.remainder;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mcodo_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.operation)
                        mcodo_pkg::OP_LOAD:
                            state_next = cmd_elem_ok ? mcodo_pkg::ST_LOAD_DIV : mcodo_pkg::ST_RESP;
                        mcodo_pkg::OP_CLEAR:
                            state_next = (len_eff == KW'(0)) ? mcodo_pkg::ST_RESP
                                                             : mcodo_pkg::ST_CLEAR;
                        mcodo_pkg::OP_SET:
                            state_next = cmd_coord_ok ? mcodo_pkg::ST_SET_DIV : mcodo_pkg::ST_RESP;
                        mcodo_pkg::OP_INC:
                            state_next = ovf_reg ? mcodo_pkg::ST_RESP : mcodo_pkg::ST_INC_CHECK;
                        mcodo_pkg::OP_READ_ELEM:
                            state_next = cmd_elem_ok ? mcodo_pkg::ST_RD_ISSUE : mcodo_pkg::ST_RESP;
                        default:
                            state_next = mcodo_pkg::ST_RESP;
                    endcase
                end
            end
            mcodo_pkg::ST_LOAD_DIV:
                if (div_rsp.done) state_next = mcodo_pkg::ST_RESP;
            mcodo_pkg::ST_SET_DIV:
                if (div_rsp.done) state_next = walk_first;
            mcodo_pkg::ST_CLEAR:
                if (k_last) state_next = mcodo_pkg::ST_RESP;
            mcodo_pkg::ST_RD_ISSUE:  state_next = mcodo_pkg::ST_RD_WAIT;
            mcodo_pkg::ST_RD_WAIT:   state_next = mcodo_pkg::ST_RESP;
            mcodo_pkg::ST_INC_CHECK:
                state_next = (pos_reg == RW'(0)) ? mcodo_pkg::ST_RESP : walk_first;
            mcodo_pkg::ST_W_RSRC:    state_next = mcodo_pkg::ST_W_RACC;
            mcodo_pkg::ST_W_RACC:    state_next = mcodo_pkg::ST_W_CALC;
            mcodo_pkg::ST_W_CALC:
            begin
                if (times_reg) state_next = mcodo_pkg::ST_W_MUL;
                else state_next = k_last ? mcodo_pkg::ST_W_END : mcodo_pkg::ST_W_RSRC;
            end
            mcodo_pkg::ST_W_MUL:     state_next = mcodo_pkg::ST_W_DIV;
            mcodo_pkg::ST_W_DIV:
                if (div_rsp.done)
                    state_next = k_last ? mcodo_pkg::ST_W_END : mcodo_pkg::ST_W_RSRC;
            mcodo_pkg::ST_W_END:
            begin
                if (!times_reg && wrap_reg) state_next = mcodo_pkg::ST_INC_CHECK;
                else state_next = mcodo_pkg::ST_RESP;
            end
            mcodo_pkg::ST_RESP:      state_next = mcodo_pkg::ST_IDLE;
            default:                 state_next = mcodo_pkg::ST_IDLE;
        endcase
    end

    // datapath, memory and remainder unit control
    always_comb
    begin
        item_next   = item_reg;
        k_next      = k_reg;
        slot_next   = slot_reg;
        pos_next    = pos_reg;
        times_next  = times_reg;
        wrap_next   = wrap_reg;
        neg_next    = neg_reg;
        coef_next   = coef_reg;
        src_next    = src_reg;
        acc_next    = acc_reg;
        prod_next   = prod_reg;
        rd_next     = rd_reg;
        adv_next    = adv_reg;
        ovf_next    = ovf_reg;
        coord_we    = 1'b0;
        coord_widx  = pos_cidx[CIW-1:0];
        coord_wdata = 16'd0;
        mem_we      = 1'b0;
        mem_waddr   = AW'(k_reg);
        mem_wdata   = 16'd0;
        mem_raddr   = AW'(k_reg);
        div_req.start    = 1'b0;
        div_req.dividend = {1'b0, mag};
        div_req.divisor  = mod_eff;
        unique case (state_reg)
            mcodo_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    item_next = cmd;
                    rd_next   = 16'd0;
                    adv_next  = 1'b0;
                    neg_next  = cmd.value[31];
                    k_next    = KW'(0);
                    case (cmd.operation)
                        mcodo_pkg::OP_LOAD:       div_req.start = cmd_elem_ok;
                        mcodo_pkg::OP_SET:        div_req.start = cmd_coord_ok;
                        mcodo_pkg::OP_CLEAR:      ovf_next = 1'b0;
                        mcodo_pkg::OP_INC:        pos_next = rank_eff;
                        mcodo_pkg::OP_READ_COORD:
                            if (cmd_coord_ok) rd_next = coord_reg[cmd_cidx[CIW-1:0]];
                        default:                  rd_next = 16'd0;
                    endcase
                end
            end
            mcodo_pkg::ST_LOAD_DIV:
            begin
                mem_waddr = item_addr;
                mem_wdata = reduced;
                mem_we    = div_rsp.done;
            end
            mcodo_pkg::ST_SET_DIV:
            begin
                if (div_rsp.done)
                begin
                    coord_we    = 1'b1;
                    coord_widx  = item_cidx[CIW-1:0];
                    coord_wdata = reduced;
                    coef_next   = reduced;
                    slot_next   = RW'(item_reg.matrix_index);
                    times_next  = 1'b1;
                end
            end
            mcodo_pkg::ST_CLEAR:
            begin
                mem_we = 1'b1;
                k_next = k_inc;
            end
            mcodo_pkg::ST_RD_ISSUE:  mem_raddr = item_addr;
            mcodo_pkg::ST_RD_WAIT:   rd_next = mem_rdata;
            mcodo_pkg::ST_INC_CHECK:
            begin
                k_next     = KW'(0);
                times_next = 1'b0;
                slot_next  = pos_reg;
                if (pos_reg == RW'(0))
                begin
                    ovf_next = 1'b1;
                end
                else if (coord_at_pos == top)
                begin
                    coord_we  = 1'b1;
                    pos_next  = pos_reg - RW'(1);
                    wrap_next = 1'b1;
                end
                else
                begin
                    coord_we    = 1'b1;
                    coord_wdata = coord_at_pos + 16'd1;
                    wrap_next   = 1'b0;
                end
            end
            mcodo_pkg::ST_W_RSRC:    mem_raddr = AW'(slot_reg) * LEN_A + AW'(k_reg);
            mcodo_pkg::ST_W_RACC:
            begin
                src_next  = mem_rdata;
                mem_raddr = AW'(k_reg);
            end
            mcodo_pkg::ST_W_CALC:
            begin
                if (times_reg)
                begin
                    acc_next  = mem_rdata;
                    prod_next = 32'(coef_reg) * 32'(src_reg);
                end
                else
                begin
                    mem_we    = 1'b1;
                    mem_wdata = sum_fix;
                    k_next    = k_inc;
                end
            end
            mcodo_pkg::ST_W_MUL:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = 33'(acc_reg) + 33'(prod_reg);
            end
            mcodo_pkg::ST_W_DIV:
            begin
                mem_wdata = div_rsp.remainder;
                mem_we    = div_rsp.done;
                if (div_rsp.done) k_next = k_inc;
            end
            mcodo_pkg::ST_W_END:
            begin
                if (!times_reg && !wrap_reg) adv_next = 1'b1;
            end
            mcodo_pkg::ST_RESP:      rd_next = rd_reg;
            default:                 rd_next = rd_reg;
        endcase
    end

    // outputs
    always_comb
    begin
        busy              = (state_reg != mcodo_pkg::ST_IDLE);
        done              = (state_reg == mcodo_pkg::ST_RESP);
        cfg_ready         = 1'b1;
        result.read_value = rd_reg | rank_dummy;
        result.advanced   = adv_reg;
        result.overflow   = ovf_reg;
    end

    // control registers and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mcodo_pkg::ST_IDLE;
            ovf_reg   <= 1'b0;
            mod_reg   <= 16'd2;
            rank_reg  <= 5'd1;
            len_reg   <= 11'd1;
            k_reg     <= '0;
            pos_reg   <= '0;
            times_reg <= 1'b0;
            wrap_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ovf_reg   <= ovf_next;
            k_reg     <= k_next;
            pos_reg   <= pos_next;
            times_reg <= times_next;
            wrap_reg  <= wrap_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    mcodo_pkg::CFG_MODULUS: mod_reg  <= cfg_data;
                    mcodo_pkg::CFG_RANK:    rank_reg <= cfg_data[4:0];
                    mcodo_pkg::CFG_LENGTH:  len_reg  <= cfg_data[10:0];
                    default:                mod_reg  <= mod_reg;
                endcase
            end
        end
    end

    // coordinate tuple
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_RANK; i++)
            begin
                coord_reg[i] <= 16'd0;
            end
        end
        else if (coord_we)
        begin
            coord_reg[coord_widx] <= coord_wdata;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        slot_reg <= slot_next;
        neg_reg  <= neg_next;
        coef_reg <= coef_next;
        src_reg  <= src_next;
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
        rd_reg   <= rd_next;
        adv_reg  <= adv_next;
    end

    // vector memory: slot-major, MAX_LENGTH words per slot
    mcodo_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_vec_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // shared remainder unit
    mcodo_rem u_rem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

endmodule

// ===== rtl/mcodo_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module mcodo_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/mcodo_rem.sv =====
// Iterative remainder unit: 33-bit dividend mod 16-bit divisor, one bit per cycle.
// Depends on mcodo_pkg.
module mcodo_rem (
    input  logic                clk,
    input  logic                rst_n,
    input  mcodo_pkg::div_req_t req,
    output mcodo_pkg::div_rsp_t rsp
);

    logic [15:0]                       rem_reg, rem_next;
    logic [mcodo_pkg::DIV_BITS-1:0]    dvd_reg, dvd_next;
    logic [15:0]                       dsr_reg, dsr_next;
    logic [5:0]                        cnt_reg, cnt_next;
    logic                              run_reg, run_next;
    logic                              done_reg, done_next;
    logic [16:0]                       trial;

    // one restoring step
    always_comb
    begin
        trial     = {rem_reg, dvd_reg[mcodo_pkg::DIV_BITS-1]};
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next = '0;
            dvd_next = req.dividend;
            dsr_next = req.divisor;
            cnt_next = mcodo_pkg::DIV_STEPS;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = 16'(trial - {1'b0, dsr_reg});
            end
            else
            begin
                rem_next = trial[15:0];
            end
            dvd_next = {dvd_reg[mcodo_pkg::DIV_BITS-2:0], 1'b0};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ===== rtl/mcodo_checker.sv =====
// Port-level checks for the modular combination odometer core.
// Depends on mcodo_pkg; bound to the top level below.
module mcodo_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            start,
    input logic            busy,
    input logic            done,
    input mcodo_pkg::res_t result
);

    // a result word only appears while a command is in flight
    assert property (@(posedge clk) disable iff (!rst_n) done |-> busy)
        else $error("done without busy");

    // an accepted command makes the block busy
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("command accepted but block not busy");

    // one result word per command, one cycle long
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("done held for more than one cycle");

    // an odometer advance never reports overflow
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.advanced) |-> !result.overflow)
        else $error("advanced together with overflow");

endmodule

bind modular_combination_odometer_core mcodo_checker u_mcodo_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
